### hw/rtl/jfas_pkg.sv
package jfas_pkg;

	localparam int unsigned NUM_AXES = 6;

	localparam logic [7:0]  HEADER_BYTE   = 8'h96;
	localparam logic [7:0]  TRAILER_BYTE  = 8'h8D;
	localparam logic [15:0] AXIS_OFFSET   = 16'd8192;
	localparam logic [14:0] THRESH_RESET  = 15'd120;

	typedef logic [3:0]         pos_t;
	typedef logic [2:0]         idx_t;
	typedef logic [13:0]        sum_t;
	typedef logic signed [15:0] axis_t;
	typedef logic [14:0]        mag_t;

	// frame byte positions: header is 0, trailer is 15
	localparam pos_t POS_HUNT     = 4'd0;
	localparam pos_t POS_SUM_LAST = 4'd12;
	localparam pos_t POS_TARGET   = 4'd14;
	localparam pos_t POS_LAST     = 4'd15;

	typedef enum logic [1:0] {
		ST_MOVE     = 2'd0,
		ST_STOP     = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_TRAILER  = 2'd3
	} status_t;

	typedef struct packed {
		logic                       chk_ok;
		axis_t [NUM_AXES-1:0]       axis;
		mag_t  [NUM_AXES-1:0]       mag;
	} frame_t;

	typedef struct packed {
		status_t                    status;
		idx_t                       index;
		logic                       positive;
		mag_t                       peak;
		axis_t [NUM_AXES-1:0]       axis;
	} result_t;

endpackage

### hw/rtl/joystick_frame_axis_select_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_ready  | rx_byte
// config   | cfg_valid/cfg_ready  | deadzone_threshold
// output   | out_valid/out_ready  | status, axis_index, axis_positive,
//          |                      | peak_magnitude, axis_x .. axis_c
//
// One byte is taken per cycle unless the trailer byte is stalled. A frame result
// is shown once its trailer byte has passed through the input register and the
// result has been loaded into the result register.
// Reset returns to header hunting and sets the threshold to 120.
// A waiting result stalls only the trailer byte; other bytes keep flowing,
// and the input register holds one more request while the output is full.
module joystick_frame_axis_select_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [14:0]         deadzone_threshold,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [2:0]          axis_index,
	output logic                axis_positive,
	output logic [14:0]         peak_magnitude,
	output logic signed [15:0]  axis_x,
	output logic signed [15:0]  axis_y,
	output logic signed [15:0]  axis_z,
	output logic signed [15:0]  axis_a,
	output logic signed [15:0]  axis_b,
	output logic signed [15:0]  axis_c
);
	import jfas_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	mag_t        thresh_q;
	logic        at_end;
	logic        out_free;
	logic        take;
	frame_t      frame;
	result_t     result;
	result_t     result_q;

	// the threshold register is always free to take a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			thresh_q <= deadzone_threshold;
		end
	end

	// advance the held byte unless it ends a frame and the result slot is busy
	assign out_free = !out_valid || out_ready;
	assign take     = valid_s1 && (!at_end || out_free);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	jfas_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (byte_s1),
		.at_end  (at_end),
		.frame   (frame)
	);

	jfas_select u_select (
		.trailer_ok (byte_s1 == TRAILER_BYTE),
		.frame      (frame),
		.threshold  (thresh_q),
		.result     (result)
	);

	// result register: load on the trailer byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take && at_end) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && at_end) begin
			result_q <= result;
		end
	end

	assign status         = result_q.status;
	assign axis_index     = result_q.index;
	assign axis_positive  = result_q.positive;
	assign peak_magnitude = result_q.peak;
	assign axis_x         = result_q.axis[0];
	assign axis_y         = result_q.axis[1];
	assign axis_z         = result_q.axis[2];
	assign axis_a         = result_q.axis[3];
	assign axis_b         = result_q.axis[4];
	assign axis_c         = result_q.axis[5];

endmodule

### hw/rtl/jfas_frame.sv
module jfas_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output logic              at_end,
	output jfas_pkg::frame_t  frame
);
	import jfas_pkg::*;

	pos_t                 pos_q;
	sum_t                 sum_q;
	logic [7:0]           prev_q;
	logic                 chk_ok_q;
	axis_t [NUM_AXES-1:0] axis_q;
	mag_t  [NUM_AXES-1:0] mag_q;

	logic [15:0] pair_val;
	axis_t       axis_new;
	mag_t        mag_new;
	idx_t        axis_sel;
	logic        axis_wr;

	// hi * 128 + lo from the held byte and the current one
	assign pair_val = {1'b0, prev_q, 7'b0} + {8'b0, rx_byte};
	assign axis_new = axis_t'(pair_val - AXIS_OFFSET);
	assign mag_new  = axis_new[15] ? mag_t'(-axis_new) : mag_t'(axis_new);
	assign axis_sel = idx_t'(pos_q[3:1] - 3'd1);
	assign axis_wr  = (pos_q[0] == 1'b0) && (pos_q != POS_HUNT) && (pos_q <= POS_SUM_LAST);
	assign at_end   = (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= '0;
		end else if (take) begin
			if (pos_q == POS_HUNT) begin
				if (rx_byte == HEADER_BYTE) begin
					pos_q <= pos_t'(1);
					sum_q <= sum_t'(HEADER_BYTE);
				end
			end else if (pos_q == POS_LAST) begin
				pos_q <= POS_HUNT;
			end else begin
				pos_q <= pos_q + pos_t'(1);
				if (pos_q <= POS_SUM_LAST) begin
					sum_q <= sum_q + {6'b0, rx_byte};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (pos_q != POS_HUNT) && (pos_q != POS_LAST)) begin
			prev_q <= rx_byte;
			if (axis_wr) begin
				axis_q[axis_sel] <= axis_new;
				mag_q[axis_sel]  <= mag_new;
			end
			if (pos_q == POS_TARGET) begin
				chk_ok_q <= (pair_val == {2'b0, sum_q});
			end
		end
	end

	assign frame.chk_ok = chk_ok_q;
	assign frame.axis   = axis_q;
	assign frame.mag    = mag_q;

endmodule

### hw/rtl/jfas_select.sv
module jfas_select (
	input  logic              trailer_ok,
	input  jfas_pkg::frame_t  frame,
	input  jfas_pkg::mag_t    threshold,
	output jfas_pkg::result_t result
);
	import jfas_pkg::*;

	always_comb begin
		idx_t best;
		mag_t best_mag;
		best     = '0;
		best_mag = frame.mag[0];
		// strict compare keeps the lowest index on ties
		for (int k = 1; k < NUM_AXES; k++) begin
			if (frame.mag[k] > best_mag) begin
				best     = idx_t'(k);
				best_mag = frame.mag[k];
			end
		end

		result = '0;
		if (!trailer_ok) begin
			result.status = ST_TRAILER;
		end else if (!frame.chk_ok) begin
			result.status = ST_CHECKSUM;
		end else begin
			result.status   = (best_mag < threshold) ? ST_STOP : ST_MOVE;
			result.index    = best;
			result.positive = (frame.axis[best] > 16'sd0);
			result.peak     = best_mag;
			result.axis     = frame.axis;
		end
	end

endmodule

### hw/rtl/jfas_checker.sv
module jfas_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [7:0]          rx_byte,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [14:0]         deadzone_threshold,
	input logic                out_valid,
	input logic                out_ready,
	input logic [1:0]          status,
	input logic [2:0]          axis_index,
	input logic                axis_positive,
	input logic [14:0]         peak_magnitude,
	input logic signed [15:0]  axis_x,
	input logic signed [15:0]  axis_y,
	input logic signed [15:0]  axis_z,
	input logic signed [15:0]  axis_a,
	input logic signed [15:0]  axis_b,
	input logic signed [15:0]  axis_c
);
	import jfas_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(axis_index)
			&& $stable(peak_magnitude) && $stable(axis_x))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CHECKSUM || status == ST_TRAILER) |->
			axis_index == 3'd0 && !axis_positive && peak_magnitude == 15'd0
			&& axis_x == 16'sd0 && axis_c == 16'sd0)
		else $error("error result carries axis data");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> axis_index <= 3'd5)
		else $error("axis index out of range");

	a_pos_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && axis_positive |-> peak_magnitude != 15'd0)
		else $error("positive axis with zero magnitude");

endmodule

bind joystick_frame_axis_select_top jfas_checker u_jfas_checker (.*);
